/* rtl/ttrc_pkg.sv */
package ttrc_pkg;

    localparam int TERM_W  = 16;
    localparam int INDEX_W = 8;
    localparam int BYTE_W  = 8;

    // Recurrence constants
    localparam logic [BYTE_W-1:0]  FIRST_OFFSET = 8'd7;
    localparam logic [11:0]        ALPHA_MUL    = 12'd17;
    localparam logic [12:0]        BETA_MUL     = 13'd31;
    localparam logic [TERM_W-1:0]  MODULUS      = 16'hFFFF;

    // Reset values of the recurrence state
    localparam logic [TERM_W-1:0]  OLDER_RESET  = 16'd1;
    localparam logic [TERM_W-1:0]  NEWER_RESET  = 16'd1;
    localparam logic [INDEX_W-1:0] INDEX_RESET  = 8'd0;

    typedef struct packed {
        logic [TERM_W-1:0]  older_term;
        logic [TERM_W-1:0]  newer_term;
        logic [INDEX_W-1:0] byte_index;
    } ttrc_state_t;

    // x mod 65535 by two end-around folds; result 0..65534
    function automatic logic [TERM_W-1:0] mod_fold(input logic [31:0] x);
        logic [TERM_W:0] s1;
        logic [TERM_W:0] s2;
        s1 = {1'b0, x[31:16]} + {1'b0, x[15:0]};
        s2 = {{TERM_W{1'b0}}, s1[TERM_W]} + {1'b0, s1[TERM_W-1:0]};
        if (s2[TERM_W-1:0] == MODULUS) begin
            mod_fold = '0;
        end else begin
            mod_fold = s2[TERM_W-1:0];
        end
    endfunction

endpackage

/* rtl/three_term_recurrence_checksum_unit.sv */
// Channel  | Dir | Ports                                        | Request
// ---------+-----+----------------------------------------------+------------------------
// input    | in  | s_valid s_ready s_data_byte s_first_byte      | one message byte
//          |     | s_last_byte                                  |
// result   | out | m_valid m_ready m_running_checksum m_is_final | checksum after the byte
//
// One byte per cycle sustained while m_ready holds; each byte passes the input register, then the result register.
// The rate is set by the recurrence loop: multiply, subtract and mod-65535 fold are combinational.
// aresetn (synchronous, active low) sets older = newer = 1, index = 0 and empties both stages.
// A stalled result holds the output register; the input register still takes one request
// while it is empty, so at most two requests wait before s_ready drops.
module three_term_recurrence_checksum_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ttrc_pkg::BYTE_W-1:0]   s_data_byte,
    input  logic                          s_first_byte,
    input  logic                          s_last_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ttrc_pkg::TERM_W-1:0]   m_running_checksum,
    output logic                          m_is_final
);

    logic                        s1_valid_reg;
    logic [ttrc_pkg::BYTE_W-1:0] s1_byte_reg;
    logic                        s1_first_reg;
    logic                        s1_last_reg;

    ttrc_pkg::ttrc_state_t       state_reg;
    ttrc_pkg::ttrc_state_t       state_next;

    logic                        m_valid_reg;
    logic [ttrc_pkg::TERM_W-1:0] m_sum_reg;
    logic                        m_final_reg;

    logic                        out_free;
    logic                        advance;
    logic                        in_take;

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || out_free;
    assign in_take  = s_valid && s_ready;

    ttrc_step u_step (
        .data_byte  (s1_byte_reg),
        .first_byte (s1_first_reg),
        .cur_state  (state_reg),
        .nxt_state  (state_next)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            s1_byte_reg  <= s_data_byte;
            s1_first_reg <= s_first_byte;
            s1_last_reg  <= s_last_byte;
        end
    end

    // Recurrence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.older_term <= ttrc_pkg::OLDER_RESET;
            state_reg.newer_term <= ttrc_pkg::NEWER_RESET;
            state_reg.byte_index <= ttrc_pkg::INDEX_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_sum_reg   <= state_next.newer_term;
            m_final_reg <= s1_last_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_running_checksum = m_sum_reg;
    assign m_is_final         = m_final_reg;

    // Checks
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && s1_first_reg) |=>
            (state_reg.byte_index == 8'd1 && state_reg.older_term == ttrc_pkg::OLDER_RESET))
        else $error("restart did not reload recurrence state");

    a_sum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_sum_reg != ttrc_pkg::MODULUS))
        else $error("checksum out of range");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready && s1_valid_reg) |-> !s_ready)
        else $error("input accepted with both stages full");

    a_advance_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("advanced byte lost before result register");

endmodule

/* rtl/ttrc_step.sv */
// One recurrence step: next state from the current state and one byte.
module ttrc_step (
    input  logic [ttrc_pkg::BYTE_W-1:0] data_byte,
    input  logic                        first_byte,
    input  ttrc_pkg::ttrc_state_t       cur_state,
    output ttrc_pkg::ttrc_state_t       nxt_state
);

    logic [11:0] alpha_full;
    logic [12:0] beta_full;
    logic [7:0]  alpha;
    logic [7:0]  beta;
    logic [8:0]  coef;
    logic [24:0] pos;
    logic [23:0] neg;
    logic [24:0] diff_pos;
    logic [23:0] diff_neg;
    logic [15:0] rem_neg;
    logic [15:0] term;

    // Index-dependent coefficients, reduced mod 256
    assign alpha_full = {4'b0, cur_state.byte_index} * ttrc_pkg::ALPHA_MUL;
    assign beta_full  = {5'b0, cur_state.byte_index} * ttrc_pkg::BETA_MUL;
    assign alpha      = alpha_full[7:0];
    assign beta       = beta_full[7:0];
    assign coef       = {1'b0, data_byte} + {1'b0, alpha};

    // Two products, both well under 32 bits
    assign pos = {16'b0, coef} * {9'b0, cur_state.newer_term};
    assign neg = {16'b0, beta} * {8'b0, cur_state.older_term};

    // Negative difference folds as (d + 1) mod 65535
    assign diff_pos = pos - {1'b0, neg};
    assign diff_neg = neg - pos[23:0] - 24'd1;
    assign rem_neg  = ttrc_pkg::mod_fold({8'b0, diff_neg});

    always_comb begin
        if (pos >= {1'b0, neg}) begin
            term = ttrc_pkg::mod_fold({7'b0, diff_pos});
        end else if (rem_neg == '0) begin
            term = '0;
        end else begin
            term = ttrc_pkg::MODULUS - rem_neg;
        end
    end

    // Restart or shift the terms
    always_comb begin
        if (first_byte) begin
            nxt_state.older_term = ttrc_pkg::OLDER_RESET;
            nxt_state.newer_term = {8'b0, data_byte} + {8'b0, ttrc_pkg::FIRST_OFFSET};
            nxt_state.byte_index = 8'd1;
        end else begin
            nxt_state.older_term = cur_state.newer_term;
            nxt_state.newer_term = term;
            nxt_state.byte_index = cur_state.byte_index + 8'd1;
        end
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned FIRST_ADD    = 7;
    localparam int unsigned ALPHA_STEP   = 17;
    localparam int unsigned BETA_STEP    = 31;
    localparam int unsigned CHECK_MOD    = 65535;
    localparam int          HOLD_CYCLES  = 48;
    localparam int          IDLE_LIMIT   = 1000;
    localparam int          TAIL_CYCLES  = 8;
    localparam int          RANDOM_ITEMS = 1090;

    typedef struct packed {
        logic [ttrc_pkg::TERM_W-1:0] checksum;
        logic                        is_final;
    } checksum_result_t;

    logic                         aclk               = 1'b0;
    logic                         aresetn            = 1'b0;
    logic                         s_valid            = 1'b0;
    logic                         s_ready;
    logic [ttrc_pkg::BYTE_W-1:0]  s_data_byte        = '0;
    logic                         s_first_byte       = 1'b0;
    logic                         s_last_byte        = 1'b0;
    logic                         m_valid;
    logic                         m_ready            = 1'b0;
    logic [ttrc_pkg::TERM_W-1:0]  m_running_checksum;
    logic                         m_is_final;

    // Recurrence state mirrored on the testbench side
    logic [ttrc_pkg::TERM_W-1:0]  pred_older = 16'd1;
    logic [ttrc_pkg::TERM_W-1:0]  pred_newer = 16'd1;
    logic [ttrc_pkg::INDEX_W-1:0] pred_index = 8'd0;

    checksum_result_t   expected_sums[$];

    int tx_max_gap    = 6;
    int rx_max_stall  = 6;
    bit hold_off_req  = 1'b0;
    int failures      = 0;
    int bytes_sent    = 0;
    int messages_sent = 0;
    int sums_checked  = 0;
    int neg_terms     = 0;
    int index_wraps   = 0;
    int hold_offs     = 0;
    int idle_cycles   = 0;

    three_term_recurrence_checksum_unit u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_first_byte       (s_first_byte),
        .s_last_byte        (s_last_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_running_checksum (m_running_checksum),
        .m_is_final         (m_is_final)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Next checksum for one byte; advances the mirrored state
    function automatic checksum_result_t predict_checksum(
                                                  input logic [ttrc_pkg::BYTE_W-1:0] data,
                                                  input logic first,
                                                  input logic last);
        int unsigned alpha;
        int unsigned beta;
        int unsigned pos;
        int unsigned neg;
        int unsigned term;
        checksum_result_t r;
        if (first) begin
            term       = data + FIRST_ADD;
            pred_older = 16'd1;
            pred_newer = term[ttrc_pkg::TERM_W-1:0];
            pred_index = 8'd1;
        end else begin
            alpha = (pred_index * ALPHA_STEP) & 32'hFF;
            beta  = (pred_index * BETA_STEP) & 32'hFF;
            pos   = (data + alpha) * pred_newer;
            neg   = beta * pred_older;
            if (pos >= neg) begin
                term = (pos - neg) % CHECK_MOD;
            end else begin
                // negative difference folds as (d + 1) mod 65535
                term = (CHECK_MOD - (neg - pos - 1) % CHECK_MOD) % CHECK_MOD;
                neg_terms++;
            end
            if (pred_index == 8'hFF) begin
                index_wraps++;
            end
            pred_older = pred_newer;
            pred_newer = term[ttrc_pkg::TERM_W-1:0];
            pred_index = pred_index + 8'd1;
        end
        r.checksum = term[ttrc_pkg::TERM_W-1:0];
        r.is_final = last;
        return r;
    endfunction

    function automatic logic [ttrc_pkg::BYTE_W-1:0] rand_byte();
        int pick;
        int raw;
        pick = $urandom_range(7);
        if (pick == 0) begin
            return 8'h00;
        end else if (pick == 1) begin
            return 8'hFF;
        end
        raw = $urandom;
        return raw[ttrc_pkg::BYTE_W-1:0];
    endfunction

    // Offer one request after a random gap; returns at the accepting edge
    task automatic send_byte(input logic [ttrc_pkg::BYTE_W-1:0] data, input logic first,
                             input logic last);
        int gap;
        gap = int'($urandom_range(tx_max_gap));
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= data;
        s_first_byte <= first;
        s_last_byte  <= last;
        do @(posedge aclk); while (!s_ready);
        expected_sums.push_back(predict_checksum(data, first, last));
        bytes_sent++;
        if (first) begin
            messages_sent++;
        end
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) begin
            send_byte(rand_byte(), i == 0, i == len - 1);
        end
    endtask

    // Stop offering and wait for every pending checksum
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge aclk);
    endtask

    // Bytes with no start on the reset state, and after a final byte
    task automatic test_after_reset();
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h7F, 1'b0, 1'b1);
    endtask

    // First and last on the same byte
    task automatic test_single_byte_messages();
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'h55, 1'b1, 1'b1);
        send_byte(8'hAA, 1'b1, 1'b1);
    endtask

    task automatic test_extreme_messages();
        logic [ttrc_pkg::BYTE_W-1:0] bytes_hi[8] = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
                                                     8'h80, 8'h01, 8'hFE};
        for (int i = 0; i < 8; i++) begin
            send_byte(bytes_hi[i], i == 0, i == 7);
        end
        for (int i = 0; i < 6; i++) begin
            send_byte(8'h00, i == 0, i == 5);
        end
    endtask

    // Long message so the byte index rolls over
    task automatic test_index_wrap();
        send_message(300);
    endtask

    // Mostly well-formed messages, some with stray start/end flags
    task automatic test_random_messages();
        int stop_at;
        int n;
        stop_at = bytes_sent + RANDOM_ITEMS;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(9) < 8) begin
                n = ($urandom_range(15) == 0) ? int'($urandom_range(64, 25))
                                              : int'($urandom_range(24, 1));
                send_message(n);
            end else begin
                n = int'($urandom_range(8, 1));
                repeat (n) begin
                    send_byte(rand_byte(), $urandom_range(7) == 0, $urandom_range(7) == 0);
                end
            end
        end
    endtask

    // Receiver holds off while bytes keep coming; then a full drain
    task automatic test_backpressure();
        tx_max_gap   = 0;
        hold_off_req = 1'b1;
        send_message(32);
        tx_max_gap = 6;
        while (hold_off_req) @(posedge aclk);
        wait_for_results();
    endtask

    task automatic test_no_idle();
        tx_max_gap   = 0;
        rx_max_stall = 0;
        send_message(40);
        send_message(60);
        tx_max_gap   = 6;
        rx_max_stall = 6;
    endtask

    // Result receiver: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_offs++;
                hold_off_req = 1'b0;
            end
            stall = int'($urandom_range(rx_max_stall));
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Compare each checksum with the oldest pending one
    always @(posedge aclk) begin
        checksum_result_t want;
        if (aresetn && m_valid && m_ready) begin
            sums_checked++;
            if (expected_sums.size() == 0) begin
                $error("checksum %0d with no request pending", m_running_checksum);
                failures++;
            end else begin
                want = expected_sums.pop_front();
                if (m_running_checksum !== want.checksum) begin
                    $error("running_checksum: expected %0d, actual %0d",
                           want.checksum, m_running_checksum);
                    failures++;
                end
                if (m_is_final !== want.is_final) begin
                    $error("is_final: expected %0d, actual %0d", want.is_final, m_is_final);
                    failures++;
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("** three_term_recurrence_checksum_unit: FAILED **");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_after_reset();
        test_single_byte_messages();
        test_extreme_messages();
        wait_for_results();
        test_index_wrap();
        test_random_messages();
        test_backpressure();
        test_no_idle();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_sums.size() != 0) begin
            $error("%0d checksums never arrived", expected_sums.size());
            failures++;
        end

        $display("run: %0d bytes in %0d messages, %0d checksums compared, %0d failures",
                 bytes_sent, messages_sent, sums_checked, failures);
        $display("      %0d negative-difference terms, %0d index rollovers, %0d long hold-offs",
                 neg_terms, index_wraps, hold_offs);
        if (failures == 0) begin
            $display("** three_term_recurrence_checksum_unit: PASSED **");
        end else begin
            $display("** three_term_recurrence_checksum_unit: FAILED **");
        end
        $finish;
    end

endmodule
